>>> hdl/rvfp_pkg.sv
`default_nettype none
package rvfp_pkg;

    // payload bytes kept for decoding
    localparam int HEAD_BYTES = 12;

    // register indexes on the write port
    localparam logic CFG_SYNC  = 1'b0;
    localparam logic CFG_COMBO = 1'b1;

    // ieee single bit patterns of the range limits
    localparam logic [31:0] HEART_LO  = 32'h4220_0000;  // 40.0
    localparam logic [31:0] HEART_HI  = 32'h4334_0000;  // 180.0
    localparam logic [31:0] BREATH_LO = 32'h4100_0000;  // 8.0
    localparam logic [31:0] BREATH_HI = 32'h420C_0000;  // 35.0
    localparam logic [31:0] DIST_LO   = 32'h3D4C_CCCD;  // 0.05
    localparam logic [31:0] DIST_HI   = 32'h40A0_0000;  // 5.0

    // byte parser phases
    typedef enum logic [9:0] {
        PH_SYNC   = 10'b00_0000_0001,
        PH_SEQ_HI = 10'b00_0000_0010,
        PH_SEQ_LO = 10'b00_0000_0100,
        PH_LEN_HI = 10'b00_0000_1000,
        PH_LEN_LO = 10'b00_0001_0000,
        PH_MARK   = 10'b00_0010_0000,
        PH_DATA   = 10'b00_0100_0000,
        PH_TRL0   = 10'b00_1000_0000,
        PH_TRL1   = 10'b01_0000_0000,
        PH_TRL2   = 10'b10_0000_0000
    } t_phase;

    // frame finish sequence
    typedef enum logic [3:0] {
        ST_RX   = 4'b0001,
        ST_PUSH = 4'b0010,
        ST_MED  = 4'b0100,
        ST_LOAD = 4'b1000
    } t_state;

    typedef struct packed {
        logic cap_seq_hi;
        logic cap_seq_lo;
        logic cap_len_hi;
        logic cap_len_lo;
        logic idx_clr;
        logic data_wr;
        logic push;
        logic med_step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic sync_hit;
        logic len_big;
        logic len_zero;
        logic data_last;
        logic med_last;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

>>> hdl/rvfp_window.sv
`default_nettype none
module rvfp_window #(
    parameter int DEPTH = 7
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [7:0]                   i_push_val,
    input  wire logic                         i_step,
    input  wire logic [$clog2(DEPTH)-1:0]     i_idx,
    output logic      [7:0]                   o_hold,
    output logic                              o_new_med
);
    localparam int IW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [7:0]    r_win [DEPTH];
    logic [IW-1:0] r_pos;
    logic [FW-1:0] r_fill;
    logic          r_upd;
    logic [7:0]    r_hold;
    logic [FW-1:0] n_fill;
    logic [7:0]    w_cand;
    logic [FW-1:0] w_lt;
    logic [FW-1:0] w_le;
    logic          w_hit;

    assign n_fill = (r_fill < FW'(DEPTH)) ? r_fill + 1'b1 : r_fill;

    // rank of the candidate among the valid entries
    always_comb begin
        w_cand = r_win[i_idx];
        w_lt   = '0;
        w_le   = '0;
        for (int j = 0; j < DEPTH; j++) begin
            if (FW'(j) < r_fill) begin
                w_lt = w_lt + FW'(r_win[j] < w_cand);
                w_le = w_le + FW'(r_win[j] <= w_cand);
            end
        end
        w_hit = (FW'(i_idx) < r_fill) && (w_lt <= (r_fill >> 1)) && (w_le > (r_fill >> 1));
    end

    // window write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_win[r_pos] <= i_push_val;
        end
    end

    // pointer, fill and held median
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fill <= '0;
            r_upd  <= 1'b0;
            r_hold <= '0;
        end else begin
            if (i_push) begin
                r_pos  <= (r_pos == IW'(DEPTH - 1)) ? '0 : r_pos + 1'b1;
                r_fill <= n_fill;
                r_upd  <= (n_fill >= FW'(3));
            end else if (i_step && r_upd && w_hit) begin
                r_hold <= w_cand;
            end
        end
    end

    assign o_hold    = r_hold;
    assign o_new_med = r_upd;
endmodule
`default_nettype wire

>>> hdl/rvfp_ctrl.sv
`default_nettype none
module rvfp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire rvfp_pkg::t_sts i_sts,
    output rvfp_pkg::t_cmd     o_cmd
);
    import rvfp_pkg::*;

    t_phase r_ph, n_ph;
    t_state r_st, n_st;
    logic   w_acc;

    assign o_ready = (r_st == ST_RX) && !((r_ph == PH_TRL2) && i_sts.out_busy);
    assign w_acc   = i_valid && o_ready;

    // parser phase and finish sequence
    always_comb begin
        n_ph = r_ph;
        n_st = r_st;
        if (w_acc) begin
            unique case (r_ph)
                PH_SYNC:   if (i_sts.sync_hit) n_ph = PH_SEQ_HI;
                PH_SEQ_HI: n_ph = PH_SEQ_LO;
                PH_SEQ_LO: n_ph = PH_LEN_HI;
                PH_LEN_HI: n_ph = PH_LEN_LO;
                PH_LEN_LO: n_ph = i_sts.len_big ? PH_SYNC : PH_MARK;
                PH_MARK:   n_ph = i_sts.len_zero ? PH_TRL0 : PH_DATA;
                PH_DATA:   if (i_sts.data_last) n_ph = PH_TRL0;
                PH_TRL0:   n_ph = PH_TRL1;
                PH_TRL1:   n_ph = PH_TRL2;
                PH_TRL2: begin
                    n_ph = PH_SYNC;
                    n_st = ST_PUSH;
                end
                default:   n_ph = PH_SYNC;
            endcase
        end
        unique case (r_st)
            ST_RX:   ;
            ST_PUSH: n_st = ST_MED;
            ST_MED:  if (i_sts.med_last) n_st = ST_LOAD;
            ST_LOAD: n_st = ST_RX;
            default: n_st = ST_RX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_SYNC;
            r_st <= ST_RX;
        end else begin
            r_ph <= n_ph;
            r_st <= n_st;
        end
    end

    // datapath commands
    always_comb begin
        o_cmd.cap_seq_hi = w_acc && (r_ph == PH_SEQ_HI);
        o_cmd.cap_seq_lo = w_acc && (r_ph == PH_SEQ_LO);
        o_cmd.cap_len_hi = w_acc && (r_ph == PH_LEN_HI);
        o_cmd.cap_len_lo = w_acc && (r_ph == PH_LEN_LO);
        o_cmd.idx_clr    = w_acc && (r_ph == PH_MARK);
        o_cmd.data_wr    = w_acc && (r_ph == PH_DATA);
        o_cmd.push       = (r_st == ST_PUSH);
        o_cmd.med_step   = (r_st == ST_MED);
        o_cmd.load       = (r_st == ST_LOAD);
    end
endmodule
`default_nettype wire

>>> hdl/rvfp_dpath.sv
`default_nettype none
module rvfp_dpath #(
    parameter int WINDOW_DEPTH = 7,
    parameter int MAX_PAYLOAD  = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_wr_en,
    input  wire logic           i_cfg_idx,
    input  wire logic [7:0]     i_cfg_wdata,
    input  wire logic [7:0]     i_rx_byte,
    input  wire rvfp_pkg::t_cmd i_cmd,
    output rvfp_pkg::t_sts      o_sts,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [15:0]         o_frame_seq,
    output logic [6:0]          o_frame_len,
    output logic                o_was_combo,
    output logic [7:0]          o_heart_bpm,
    output logic [5:0]          o_breath_rpm,
    output logic [31:0]         o_distance_bits,
    output logic                o_target_seen
);
    import rvfp_pkg::*;

    localparam int XW = $clog2(MAX_PAYLOAD + 1);
    localparam int MW = $clog2(WINDOW_DEPTH);

    logic [7:0]    r_sync;
    logic [6:0]    r_combo;
    logic [15:0]   r_seq;
    logic [15:0]   r_len;
    logic [XW-1:0] r_idx;
    logic [7:0]    r_head [HEAD_BYTES];
    logic [MW-1:0] r_mi;
    logic          r_was_combo;
    logic [31:0]   r_dist;
    logic          r_target;
    logic          r_out_valid;
    logic [31:0]   w_hr;
    logic [31:0]   w_br;
    logic [31:0]   w_ds;
    logic          w_combo;
    logic          w_hr_ok;
    logic          w_br_ok;
    logic          w_ds_ok;
    logic [7:0]    w_heart;
    logic [7:0]    w_breath;
    logic          w_heart_new;

    // floor(v + 0.5) for a positive single from 8 up to below 255.5
    function automatic logic [7:0] f_round(input logic [31:0] b);
        logic [7:0]  sh;
        logic [23:0] t;
        logic [8:0]  r;
        sh = 8'd149 - b[30:23];
        t  = {1'b1, b[22:0]} >> sh;
        r  = t[8:0] + 9'd1;
        return r[8:1];
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync  <= 8'd1;
            r_combo <= 7'd12;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_SYNC:  r_sync  <= i_cfg_wdata;
                CFG_COMBO: r_combo <= i_cfg_wdata[6:0];
                default:   ;
            endcase
        end
    end

    // header fields and payload index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
            r_len <= '0;
            r_idx <= '0;
        end else begin
            if (i_cmd.cap_seq_hi) r_seq <= {i_rx_byte, 8'h00};
            if (i_cmd.cap_seq_lo) r_seq <= {r_seq[15:8], i_rx_byte};
            if (i_cmd.cap_len_hi) r_len <= {i_rx_byte, 8'h00};
            if (i_cmd.cap_len_lo) r_len <= {r_len[15:8], i_rx_byte};
            if (i_cmd.idx_clr)    r_idx <= '0;
            else if (i_cmd.data_wr) r_idx <= r_idx + 1'b1;
        end
    end

    // payload head store
    always_ff @(posedge i_clk) begin
        if (i_cmd.data_wr && (16'(r_idx) < 16'(HEAD_BYTES))) begin
            r_head[r_idx[3:0]] <= i_rx_byte;
        end
    end

    assign o_sts.sync_hit  = (i_rx_byte == r_sync);
    assign o_sts.len_big   = ({r_len[15:8], i_rx_byte} > 16'(MAX_PAYLOAD));
    assign o_sts.len_zero  = (r_len == 16'd0);
    assign o_sts.data_last = ((16'(r_idx) + 16'd1) >= r_len);
    assign o_sts.med_last  = (r_mi == MW'(WINDOW_DEPTH - 1));
    assign o_sts.out_busy  = r_out_valid;

    // decode and range check of the three readings
    always_comb begin
        w_hr    = {r_head[3], r_head[2], r_head[1], r_head[0]};
        w_br    = {r_head[7], r_head[6], r_head[5], r_head[4]};
        w_ds    = {r_head[11], r_head[10], r_head[9], r_head[8]};
        w_combo = (r_len == {9'd0, r_combo});
        w_hr_ok = !w_hr[31] && (w_hr >= HEART_LO) && (w_hr <= HEART_HI);
        w_br_ok = !w_br[31] && (w_br >= BREATH_LO) && (w_br <= BREATH_HI);
        w_ds_ok = !w_ds[31] && (w_ds > DIST_LO) && (w_ds < DIST_HI);
    end

    rvfp_window #(.DEPTH(WINDOW_DEPTH)) u_heart (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_cmd.push && w_combo && w_hr_ok),
        .i_push_val (f_round(w_hr)),
        .i_step     (i_cmd.med_step),
        .i_idx      (r_mi),
        .o_hold     (w_heart),
        .o_new_med  (w_heart_new)
    );

    rvfp_window #(.DEPTH(WINDOW_DEPTH)) u_breath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_cmd.push && w_combo && w_br_ok),
        .i_push_val (f_round(w_br)),
        .i_step     (i_cmd.med_step),
        .i_idx      (r_mi),
        .o_hold     (w_breath),
        .o_new_med  ()
    );

    // median sweep counter, distance and target flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mi        <= '0;
            r_dist      <= '0;
            r_target    <= 1'b0;
            r_was_combo <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_mi        <= '0;
                r_was_combo <= w_combo;
                if (w_combo && w_ds_ok) r_dist <= w_ds;
            end else if (i_cmd.med_step && !o_sts.med_last) begin
                r_mi <= r_mi + 1'b1;
            end
            // heart window holds three or more readings once pushed
            if (i_cmd.med_step && w_heart_new) r_target <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_frame_seq     <= r_seq;
            o_frame_len     <= r_len[6:0];
            o_was_combo     <= r_was_combo;
            o_heart_bpm     <= w_heart;
            o_breath_rpm    <= w_breath[5:0];
            o_distance_bits <= r_dist;
            o_target_seen   <= r_target;
        end
    end

    assign o_valid = r_out_valid;
endmodule
`default_nettype wire

>>> hdl/radar_vitals_frame_parser_median_top.sv
// radar vital-signs frame parser with median filtering
// input channel: one received byte per transfer (i_valid / o_ready)
// output channel: one result per completed frame (o_valid / i_ready)
// config port: i_cfg_wr_en with i_cfg_idx 0 = sync byte, 1 = combo length
// a byte is taken when i_valid and o_ready are both high; every byte inside
// a frame but the last trailer byte is accepted back to back
// after the last trailer byte the block pushes the readings into the windows,
// then ranks one window entry per cycle for the median over all WINDOW_DEPTH
// entries, then loads the result register and raises o_valid; o_ready is low
// from that transfer until the result register is loaded
// a waiting result does not stop byte intake; only the last trailer byte
// of the next frame is held off until the receiver takes the result
// reset (synchronous, active low) returns the parser to sync search, clears
// windows, held values, target flag and the result valid, and loads the
// sync byte 1 and combo length 12
`default_nettype none
module radar_vitals_frame_parser_median_top #(
    parameter int WINDOW_DEPTH = 7,
    parameter int MAX_PAYLOAD  = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_frame_seq,
    output logic [6:0]       o_frame_len,
    output logic             o_was_combo,
    output logic [7:0]       o_heart_bpm,
    output logic [5:0]       o_breath_rpm,
    output logic [31:0]      o_distance_bits,
    output logic             o_target_seen
);
    import rvfp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    rvfp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    rvfp_dpath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_rx_byte       (i_rx_byte),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_seq     (o_frame_seq),
        .o_frame_len     (o_frame_len),
        .o_was_combo     (o_was_combo),
        .o_heart_bpm     (o_heart_bpm),
        .o_breath_rpm    (o_breath_rpm),
        .o_distance_bits (o_distance_bits),
        .o_target_seen   (o_target_seen)
    );
endmodule
`default_nettype wire

>>> hdl/rvfp_checker.sv
`default_nettype none
module rvfp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [15:0] o_frame_seq,
    input wire logic [7:0]  o_heart_bpm,
    input wire logic [5:0]  o_breath_rpm,
    input wire logic        o_target_seen
);
    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_seq) && $stable(o_heart_bpm))
        else $error("stalled result changed");

    // held heart rate is zero or a filtered in-range value
    a_heart_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heart_bpm == 8'd0) || (o_heart_bpm >= 8'd40 && o_heart_bpm <= 8'd180))
        else $error("heart rate out of range");

    // a heart rate appears only together with the target flag; without it the breath rate is at most 35
    a_target_heart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_target_seen |-> o_heart_bpm == 8'd0 && o_breath_rpm <= 6'd35)
        else $error("heart rate without target flag");
endmodule

bind radar_vitals_frame_parser_median_top rvfp_checker u_rvfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_frame_seq   (o_frame_seq),
    .o_heart_bpm   (o_heart_bpm),
    .o_breath_rpm  (o_breath_rpm),
    .o_target_seen (o_target_seen)
);
`default_nettype wire

>>> verif/rvfp_vitals_checker.sv
`timescale 1ns / 1ps
// watches the byte, result and register channels, predicts every frame
// result and compares each result transfer against the oldest prediction
module rvfp_vitals_checker #(
    parameter int WINDOW_DEPTH = 7,
    parameter int MAX_PAYLOAD  = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_valid,
    input  wire logic        o_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        o_valid,
    input  wire logic        i_ready,
    input  wire logic [15:0] o_frame_seq,
    input  wire logic [6:0]  o_frame_len,
    input  wire logic        o_was_combo,
    input  wire logic [7:0]  o_heart_bpm,
    input  wire logic [5:0]  o_breath_rpm,
    input  wire logic [31:0] o_distance_bits,
    input  wire logic        o_target_seen,
    output int               o_fail_count,
    output int               o_frames_due,
    output int               o_frames_checked
);
    import rvfp_pkg::*;

    typedef struct packed {
        logic [15:0] seq;
        logic [6:0]  len;
        logic        combo;
        logic [7:0]  heart;
        logic [5:0]  breath;
        logic [31:0] dist_bits;
        logic        target;
    } t_vitals;

    localparam int CH_HEART  = 0;
    localparam int CH_BREATH = 1;

    t_vitals     vitals_due[$];
    logic [7:0]  sync_val;
    logic [6:0]  combo_len;
    t_phase      phase;
    logic [15:0] seq_acc;
    logic [15:0] len_acc;
    int          pay_pos;
    logic [7:0]  head [HEAD_BYTES];
    logic [7:0]  rate_win [2][WINDOW_DEPTH];
    int          rate_pos [2];
    int          rate_fill [2];
    logic [7:0]  rate_hold [2];
    logic [31:0] dist_hold;
    logic        target;

    assign o_frames_due = vitals_due.size();

    // positive floats order like their bit patterns; sign or nan fails
    function automatic bit rate_in_range(logic [31:0] w, logic [31:0] lo, logic [31:0] hi);
        return !w[31] && w >= lo && w <= hi;
    endfunction

    // floor(v + 0.5) for v in 8..180, exact in integer form
    function automatic logic [7:0] round_half_up(logic [31:0] w);
        int          e;
        logic [31:0] m;
        e = int'(w[30:23]) - 127;
        m = {8'd0, 1'b1, w[22:0]};
        return 8'((m + (32'd1 << (22 - e))) >> (23 - e));
    endfunction

    function automatic logic [31:0] head_word(int at);
        return {head[at + 3], head[at + 2], head[at + 1], head[at]};
    endfunction

    // push a reading into one window and refresh the upper median
    task automatic push_rate(input int ch, input logic [31:0] w, input logic [31:0] lo,
                             input logic [31:0] hi, output bit made);
        logic [7:0] srt [WINDOW_DEPTH];
        logic [7:0] key;
        int         j;
        made = 0;
        if (rate_in_range(w, lo, hi)) begin
            rate_win[ch][rate_pos[ch]] = round_half_up(w);
            rate_pos[ch] = (rate_pos[ch] + 1) % WINDOW_DEPTH;
            if (rate_fill[ch] < WINDOW_DEPTH) rate_fill[ch]++;
            if (rate_fill[ch] >= 3) begin
                for (int i = 0; i < rate_fill[ch]; i++) srt[i] = rate_win[ch][i];
                for (int i = 1; i < rate_fill[ch]; i++) begin
                    key = srt[i];
                    j = i;
                    while (j > 0 && srt[j - 1] > key) begin
                        srt[j] = srt[j - 1];
                        j--;
                    end
                    srt[j] = key;
                end
                rate_hold[ch] = srt[rate_fill[ch] / 2];
                made = 1;
            end
        end
    endtask

    // advance the byte parser by one accepted byte
    task automatic parse_rx_byte(input logic [7:0] b);
        bit      made;
        t_vitals v;
        case (phase)
            PH_SYNC: if (b == sync_val) phase = PH_SEQ_HI;
            PH_SEQ_HI: begin
                seq_acc = {b, 8'd0};
                phase = PH_SEQ_LO;
            end
            PH_SEQ_LO: begin
                seq_acc[7:0] = b;
                phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_acc = {b, 8'd0};
                phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_acc[7:0] = b;
                phase = (len_acc > MAX_PAYLOAD) ? PH_SYNC : PH_MARK;
            end
            PH_MARK: begin
                pay_pos = 0;
                phase = (len_acc == 0) ? PH_TRL0 : PH_DATA;
            end
            PH_DATA: begin
                if (pay_pos < HEAD_BYTES) head[pay_pos] = b;
                pay_pos++;
                if (pay_pos >= len_acc) phase = PH_TRL0;
            end
            PH_TRL0: phase = PH_TRL1;
            PH_TRL1: phase = PH_TRL2;
            default: begin
                if (len_acc == {9'd0, combo_len}) begin
                    push_rate(CH_HEART, head_word(0), HEART_LO, HEART_HI, made);
                    if (made) target = 1;
                    push_rate(CH_BREATH, head_word(4), BREATH_LO, BREATH_HI, made);
                    if (!head[11][7] && head_word(8) > DIST_LO && head_word(8) < DIST_HI)
                        dist_hold = head_word(8);
                end
                v.seq       = seq_acc;
                v.len       = len_acc[6:0];
                v.combo     = (len_acc == {9'd0, combo_len});
                v.heart     = rate_hold[CH_HEART];
                v.breath    = rate_hold[CH_BREATH][5:0];
                v.dist_bits = dist_hold;
                v.target    = target;
                vitals_due.push_back(v);
                phase = PH_SYNC;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    // model state, then one compare per result transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vitals_due.delete();
            sync_val  = 8'd1;
            combo_len = 7'd12;
            phase     = PH_SYNC;
            seq_acc   = '0;
            len_acc   = '0;
            pay_pos   = 0;
            for (int c = 0; c < 2; c++) begin
                for (int i = 0; i < WINDOW_DEPTH; i++) rate_win[c][i] = '0;
                rate_pos[c]  = 0;
                rate_fill[c] = 0;
                rate_hold[c] = '0;
            end
            dist_hold = '0;
            target    = 0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == CFG_SYNC) sync_val = i_cfg_wdata;
                else combo_len = i_cfg_wdata[6:0];
            end
            if (i_valid && o_ready) parse_rx_byte(i_rx_byte);
            if (o_valid && i_ready) begin
                o_frames_checked++;
                if (vitals_due.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, seq %0h", $time,
                             o_frame_seq);
                    o_fail_count++;
                end else begin
                    check_field("frame_seq", vitals_due[0].seq, o_frame_seq);
                    check_field("frame_len", vitals_due[0].len, o_frame_len);
                    check_field("was_combo", vitals_due[0].combo, o_was_combo);
                    check_field("heart_bpm", vitals_due[0].heart, o_heart_bpm);
                    check_field("breath_rpm", vitals_due[0].breath, o_breath_rpm);
                    check_field("distance_bits", vitals_due[0].dist_bits, o_distance_bits);
                    check_field("target_seen", vitals_due[0].target, o_target_seen);
                    void'(vitals_due.pop_front());
                end
            end
        end
    end

    initial begin
        o_fail_count     = 0;
        o_frames_checked = 0;
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import rvfp_pkg::*;

    localparam int RUN_LIMIT  = 800000;
    localparam int HOLD_START = 3000;
    localparam int HOLD_LEN   = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_idx;
    logic [7:0]  i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_frame_seq;
    logic [6:0]  o_frame_len;
    logic        o_was_combo;
    logic [7:0]  o_heart_bpm;
    logic [5:0]  o_breath_rpm;
    logic [31:0] o_distance_bits;
    logic        o_target_seen;
    int          fail_count;
    int          frames_due;
    int          frames_checked;

    int          cycle_count;
    int          bytes_sent;
    int          burst_left;
    int          cfg_writes;
    logic [7:0]  cur_sync;
    logic [6:0]  cur_combo;

    radar_vitals_frame_parser_median_top dut (.*);

    rvfp_vitals_checker vitals_chk (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_idx, .i_cfg_wdata,
        .i_valid, .o_ready, .i_rx_byte, .o_valid, .i_ready,
        .o_frame_seq, .o_frame_len, .o_was_combo, .o_heart_bpm, .o_breath_rpm,
        .o_distance_bits, .o_target_seen,
        .o_fail_count(fail_count), .o_frames_due(frames_due),
        .o_frames_checked(frames_checked)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: changing stall pattern plus one long hold-off
    initial begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int cyc;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        cyc = 0;
        i_ready = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == HOLD_START) hold_left = HOLD_LEN;
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 0;
            end else if (mode == 0) begin
                i_ready <= 1;
            end else if (mode == 1) begin
                i_ready <= $urandom_range(0, 1);
            end else begin
                i_ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // one byte transfer, in bursts with random gaps
    task automatic send_byte(input logic [7:0] b);
        logic r;
        int   gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid   <= 1;
        i_rx_byte <= b;
        do begin
            @(negedge i_clk);
            r = o_ready;
            @(posedge i_clk);
        end while (!r);
        bytes_sent++;
    endtask

    // sync, header, and for a length up to 64 also marker, payload with readings up front, trailer
    task automatic send_frame(input logic [15:0] seq, input logic [15:0] len,
                              input logic [31:0] hr, input logic [31:0] br,
                              input logic [31:0] ds, input logic [7:0] mark);
        logic [95:0] readings;
        readings = {ds, br, hr};
        send_byte(cur_sync);
        send_byte(seq[15:8]);
        send_byte(seq[7:0]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (len <= 64) begin
            send_byte(mark);
            for (int i = 0; i < len; i++)
                send_byte(i < HEAD_BYTES ? readings[8 * i +: 8] : 8'($urandom));
            repeat (3) send_byte(8'($urandom));
        end
    endtask

    // mostly in range, plus bounds, nan and arbitrary patterns
    function automatic logic [31:0] pick_reading(logic [31:0] lo, logic [31:0] hi);
        case ($urandom_range(0, 9))
            6: return lo;
            7: return hi;
            8: return 32'h7F80_0000 | 32'($urandom_range(1, 32'h7F_FFFF));
            9: return $urandom;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    task automatic send_vitals(input logic [15:0] len);
        send_frame(16'($urandom), len, pick_reading(HEART_LO, HEART_HI),
                   pick_reading(BREATH_LO, BREATH_HI), pick_reading(DIST_LO, DIST_HI),
                   8'($urandom));
    endtask

    // register write once the block has gone quiet
    task automatic write_reg(input logic idx, input logic [7:0] val);
        i_valid <= 0;
        while (frames_due != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        cfg_writes++;
        if (idx == CFG_SYNC) cur_sync = val;
        else cur_combo = val[6:0];
    endtask

    // well-formed frames with random content, some broken ones and noise
    task automatic random_traffic(input int n_bytes);
        int stop_at;
        int r;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                send_vitals({9'd0, cur_combo});
            end else if (r < 75) begin
                send_vitals(($urandom_range(0, 4) == 0) ? 16'($urandom_range(17, 64))
                                                         : 16'($urandom_range(0, 16)));
            end else if (r < 85) begin
                send_vitals(($urandom_range(0, 1) == 0) ? 16'($urandom_range(65, 255))
                                                         : 16'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n     = 0;
        i_cfg_wr_en = 0;
        i_cfg_idx   = CFG_SYNC;
        i_cfg_wdata = '0;
        i_valid     = 0;
        i_rx_byte   = '0;
        cycle_count = 0;
        bytes_sent  = 0;
        burst_left  = 0;
        cfg_writes  = 0;
        cur_sync    = 8'd1;
        cur_combo   = 7'd12;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: range bounds, half values, nan, signs, odd lengths
        send_frame(16'h0000, 16'd12, HEART_LO, BREATH_LO, DIST_LO, 8'h00);
        send_frame(16'hFFFF, 16'd12, HEART_HI, BREATH_HI, DIST_HI, 8'hFF);
        send_frame(16'h1234, 16'd12, 32'h4222_0000, 32'h4108_0000, 32'h3D4C_CCCE, cur_sync);
        send_frame(16'h8001, 16'd12, 32'h4333_8000, 32'h420A_0000, 32'h409F_FFFF, 8'h55);
        send_frame(16'h7FFE, 16'd12, 32'h421F_FFFF, 32'h420C_0001, 32'h7FC0_0000, 8'hAA);
        send_frame(16'h00FF, 16'd12, 32'h7FC0_0001, 32'hC100_0000, 32'hBF80_0000, 8'h01);
        send_frame(16'hFF00, 16'd12, 32'hFFFF_FFFF, 32'h7F80_0000, 32'h8000_0000, 8'h01);
        send_frame(16'h0F0F, 16'd0, '0, '0, '0, 8'h01);
        send_frame(16'hF0F0, 16'd64, 32'h0101_0101, '0, '0, cur_sync);
        send_frame(16'h2222, 16'd65, '0, '0, '0, 8'h00);
        send_frame(16'h3333, 16'hFF00, '0, '0, '0, 8'h00);
        repeat (6) send_vitals(16'd12);

        // register settings, the extremes among them
        write_reg(CFG_SYNC, 8'd1);
        write_reg(CFG_COMBO, 8'd12);
        random_traffic(330);
        write_reg(CFG_SYNC, 8'h00);
        write_reg(CFG_COMBO, 8'd64);
        random_traffic(330);
        write_reg(CFG_SYNC, 8'hFF);
        write_reg(CFG_COMBO, 8'd0);
        random_traffic(330);
        write_reg(CFG_SYNC, 8'h5A);
        write_reg(CFG_COMBO, 8'd5);
        random_traffic(330);
        write_reg(CFG_SYNC, 8'hC3);
        write_reg(CFG_COMBO, 8'd12);
        random_traffic(260);

        i_valid <= 0;
        while (frames_due != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("bytes sent %0d, frame results checked %0d, register writes %0d",
                 bytes_sent, frames_checked, cfg_writes);
        $display("sync values 00/01/5A/C3/FF, combo lengths 0/5/12/64, long receiver hold");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
